// ----- hw/rtl/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;

    localparam int DEF_MAX_PAYLOAD = 2048;

    localparam logic [11:0] RST_MAX_LENGTH = 12'd2048;
    localparam logic [7:0]  RST_TIMEOUT    = 8'd10;

    typedef enum logic [2:0] {
        EV_DATA    = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_BADLEN  = 3'd2,
        EV_BADFOOT = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]  header_first_byte;
        logic [15:0] footer_word;
        logic [11:0] max_length;
        logic [7:0]  timeout_seconds;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/sfr_rx_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfr_ev_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sfr_ev_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] protocol_id;
    logic [11:0] message_length;
    logic        last;

    modport source (output valid, output event_res, output data_byte, output protocol_id,
                    output message_length, output last, input ready);
    modport sink   (input valid, input event_res, input data_byte, input protocol_id,
                    input message_length, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/serial_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  beat contents
// i_rx     in   operation (byte/tick), rx_byte
// o_ev     out  event_res, data_byte, protocol_id, message_length, last
// cfg      in   i_cfg_we / i_cfg_addr / i_cfg_wdata, write only
//
// One beat per cycle sustained while the output is not stalled; each beat is
// handled by the frame state machine; any result is registered on the next edge.
// A held output beat stalls i_rx only if the sink is not ready in that cycle.
// Reset is synchronous active low; returns to header hunt, config to defaults.

module serial_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire [CFG_DATA_W-1:0] i_cfg_wdata,
    sfr_rx_if.sink               i_rx,
    sfr_ev_if.source             o_ev
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first_byte <= '0;
            r_cfg.footer_word       <= '0;
            r_cfg.max_length        <= RST_MAX_LENGTH;
            r_cfg.timeout_seconds   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HDR_FIRST:  r_cfg.header_first_byte <= i_cfg_wdata[7:0];
                CFG_FOOTER:     r_cfg.footer_word       <= i_cfg_wdata;
                CFG_MAX_LENGTH: r_cfg.max_length        <= i_cfg_wdata[11:0];
                CFG_TIMEOUT:    r_cfg.timeout_seconds   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    sfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_rx    (i_rx),
        .o_ev    (o_ev)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sfr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfr_core
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cfg         i_cfg,
    sfr_rx_if.sink       i_rx,
    sfr_ev_if.source     o_ev
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SIG2 = 3'd1,
        PH_HDR  = 3'd2,
        PH_DATA = 3'd3,
        PH_FOOT = 3'd4
    } t_phase;

    localparam logic [15:0] LimitCap = 16'(MAX_PAYLOAD);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_field_cnt, n_field_cnt;
    logic [15:0] r_frame_protocol, n_frame_protocol;
    logic [15:0] r_frame_length, n_frame_length;
    logic [11:0] r_payload_cnt, n_payload_cnt;
    logic [7:0]  r_footer_hi, n_footer_hi;
    logic [7:0]  r_elapsed, n_elapsed;

    logic        r_out_valid;
    t_event      r_out_event, n_out_event;
    logic [7:0]  r_out_data, n_out_data;
    logic [15:0] r_out_protocol;
    logic [11:0] r_out_length, n_out_length;
    logic        r_out_last, n_out_last;

    logic        n_emit;
    logic        accept;
    logic [15:0] limit;
    logic [15:0] max_len_ext;

    assign i_rx.ready = !r_out_valid || o_ev.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    assign max_len_ext = {4'b0, i_cfg.max_length};
    assign limit       = (max_len_ext < LimitCap) ? max_len_ext : LimitCap;
    assign n_out_length = (n_frame_length > 16'd4095) ? 12'hFFF : n_frame_length[11:0];

    always_comb begin
        n_phase          = r_phase;
        n_field_cnt      = r_field_cnt;
        n_frame_protocol = r_frame_protocol;
        n_frame_length   = r_frame_length;
        n_payload_cnt    = r_payload_cnt;
        n_footer_hi      = r_footer_hi;
        n_elapsed        = r_elapsed;
        n_emit           = 1'b0;
        n_out_event      = EV_DATA;
        n_out_data       = 8'd0;
        n_out_last       = 1'b0;

        if (i_rx.operation) begin
            if (r_phase != PH_HUNT) begin
                if (r_elapsed >= i_cfg.timeout_seconds) begin
                    n_phase     = PH_HUNT;
                    n_emit      = 1'b1;
                    n_out_event = EV_TIMEOUT;
                end else if (r_elapsed != 8'hFF) begin
                    n_elapsed = r_elapsed + 8'd1;
                end
            end
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    n_payload_cnt = '0;
                    if (i_rx.rx_byte == i_cfg.header_first_byte) begin
                        n_phase   = PH_SIG2;
                        n_elapsed = '0;
                    end
                end
                PH_SIG2: begin
                    n_phase     = PH_HDR;
                    n_field_cnt = '0;
                end
                PH_HDR: begin
                    case (r_field_cnt)
                        2'd0:    n_frame_protocol = {i_rx.rx_byte, 8'd0};
                        2'd1:    n_frame_protocol = {r_frame_protocol[15:8], i_rx.rx_byte};
                        2'd2:    n_frame_length   = {i_rx.rx_byte, 8'd0};
                        default: n_frame_length   = {r_frame_length[15:8], i_rx.rx_byte};
                    endcase
                    n_field_cnt = r_field_cnt + 2'd1;
                    if (r_field_cnt == 2'd3) begin
                        n_payload_cnt = '0;
                        n_emit        = 1'b1;
                        if (n_frame_length > limit) begin
                            n_phase     = PH_HUNT;
                            n_out_event = EV_BADLEN;
                        end else if (n_frame_length == 16'd0) begin
                            n_phase     = PH_FOOT;
                            n_out_event = EV_EMPTY;
                            n_out_last  = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                            n_emit  = 1'b0;
                        end
                    end
                end
                PH_DATA: begin
                    n_payload_cnt = r_payload_cnt + 12'd1;
                    n_emit        = 1'b1;
                    n_out_event   = EV_DATA;
                    n_out_data    = i_rx.rx_byte;
                    if ({4'b0, n_payload_cnt} >= r_frame_length) begin
                        n_out_last  = 1'b1;
                        n_phase     = PH_FOOT;
                        n_field_cnt = '0;
                    end
                end
                PH_FOOT: begin
                    if (r_field_cnt == 2'd0) begin
                        n_footer_hi = i_rx.rx_byte;
                        n_field_cnt = 2'd1;
                    end else begin
                        n_field_cnt = '0;
                        n_phase     = PH_HUNT;
                        if ({r_footer_hi, i_rx.rx_byte} != i_cfg.footer_word) begin
                            n_emit      = 1'b1;
                            n_out_event = EV_BADFOOT;
                        end
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_field_cnt      <= '0;
            r_frame_protocol <= '0;
            r_frame_length   <= '0;
            r_payload_cnt    <= '0;
            r_footer_hi      <= '0;
            r_elapsed        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_phase          <= n_phase;
                r_field_cnt      <= n_field_cnt;
                r_frame_protocol <= n_frame_protocol;
                r_frame_length   <= n_frame_length;
                r_payload_cnt    <= n_payload_cnt;
                r_footer_hi      <= n_footer_hi;
                r_elapsed        <= n_elapsed;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_ev.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept && n_emit) begin
            r_out_event    <= n_out_event;
            r_out_data     <= n_out_data;
            r_out_protocol <= n_frame_protocol;
            r_out_length   <= n_out_length;
            r_out_last     <= n_out_last;
        end
    end

    assign o_ev.valid          = r_out_valid;
    assign o_ev.event_res      = r_out_event;
    assign o_ev.data_byte      = r_out_data;
    assign o_ev.protocol_id    = r_out_protocol;
    assign o_ev.message_length = r_out_length;
    assign o_ev.last           = r_out_last;

    // a held beat must block intake
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_ev.ready) |-> !i_rx.ready)
        else $error("intake open while result stalled");

    a_payload_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> ({4'b0, r_payload_cnt} < r_frame_length))
        else $error("payload count past frame length");

    a_tick_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx.operation && r_phase == PH_HUNT) |=> (r_phase == PH_HUNT))
        else $error("tick left hunt");

    a_early_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx.operation && r_phase != PH_HUNT
         && r_elapsed < i_cfg.timeout_seconds) |=> (r_phase != PH_HUNT))
        else $error("timeout before limit");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_event == EV_DATA || r_out_event == EV_EMPTY))
        else $error("last flag on non-payload event");

endmodule

`default_nettype wire
